/* design/sle_pkg.sv */
// shared constants, result kinds and the capacity helper for the serial line editor
// no dependencies; imported by serial_line_editor_top
package sle_pkg;

	// depth of the external line store, including the terminator slot
	localparam int LINE_DEPTH = 256;

	// character codes
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;

	// largest stored count that the line store and the 8-bit counter allow
	localparam logic [7:0] DEPTH_CAP = 8'((LINE_DEPTH - 1 > 255) ? 255 : LINE_DEPTH - 1);

	// size register width and reset value
	localparam int          LEN_W     = 9;
	localparam logic [8:0]  LEN_RESET = 9'd256;

	// kind of result burst held in the result register
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_STORE = 2'd0;
	localparam kind_t KIND_END   = 2'd1;
	localparam kind_t KIND_ERASE = 2'd2;

	// beat counter within one burst
	typedef logic [1:0] beat_t;

	// usable characters for a given buffer size
	function automatic logic [7:0] cap_of(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] c;
		c = (len == '0) ? '0 : len - 1'b1;
		if (c > {1'b0, DEPTH_CAP}) begin
			c = {1'b0, DEPTH_CAP};
		end
		return c[7:0];
	endfunction

	// index of the final beat of a burst
	function automatic beat_t last_beat(input kind_t k);
		beat_t b;
		case (k)
			KIND_END:   b = 2'd1;
			KIND_ERASE: b = 2'd2;
			default:    b = 2'd0;
		endcase
		return b;
	endfunction

endpackage

/* design/serial_line_editor_top.sv */
// serial line editor: assembles a terminal line from received bytes and produces echo
// and line store results; depends on sle_pkg
//
// channel      dir  fields
// s_axis       in   tdata[7:0] rx_byte
// m_axis       out  tdata echo_byte, store_index, line_length; tuser flags; tlast last
// cfg          in   cfg_we / cfg_wdata[8:0] max_line_len
//
// a byte is taken into the input register, decoded against the line state and moved
// to the result register, which then gives one result per cycle while m_axis_tready
// is high: one for a stored byte, two for a line end, three for an erase; dropped
// bytes leave with no result. the result burst length in the result register sets
// the rate; the first result is valid once the byte is in the result register. while
// a burst waits on m_axis_tready the input register holds one more byte; bytes without
// a result still pass through. arst_n clears the line state and sets the size to 256.
module serial_line_editor_top
	import sle_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// size register write
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	// received bytes
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
	// echo and store results
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] echo_byte, [15:8] store_index, [23:16] line_length
	output logic [3:0]       m_axis_tuser,   // [0] tx_valid, [1] store_valid, [2] line_done, [3] line_status
	output logic             m_axis_tlast
);

	// size register, kept as a ready-made capacity
	logic [7:0] cap_q;

	// line state
	logic [7:0] count_q;
	logic       ovf_q;
	logic       skip_q;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;

	// result register
	logic       v_s2;
	kind_t      kind_s2;
	logic [7:0] data_s2;
	logic [7:0] idx_s2;
	logic       stat_s2;
	beat_t      beat_q;

	// decode
	logic drop_lf, is_end, is_erase, is_store, has_res;
	logic s2_free, adv_s1, out_xfer;

	// capacity follows the size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cap_of(LEN_RESET);
		end else if (cfg_we) begin
			cap_q <= cap_of(cfg_wdata);
		end
	end

	// classify the byte in the input register
	always_comb begin
		drop_lf  = skip_q && (byte_s1 == CH_LF);
		is_end   = !drop_lf && ((byte_s1 == CH_CR) || (byte_s1 == CH_LF));
		is_erase = !drop_lf && !is_end && ((byte_s1 == CH_BS) || (byte_s1 == CH_DEL))
			&& (count_q != 8'd0);
		is_store = !drop_lf && !is_end && !is_erase && (count_q < cap_q);
		has_res  = is_end || is_erase || is_store;
	end

	// handshake between the two registers
	assign out_xfer      = m_axis_tvalid && m_axis_tready;
	assign s2_free       = !v_s2 || (out_xfer && m_axis_tlast);
	assign adv_s1        = v_s1 && (!has_res || s2_free);
	assign s_axis_tready = !v_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// line state update as a byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
			ovf_q   <= 1'b0;
			skip_q  <= 1'b0;
		end else if (adv_s1) begin
			skip_q <= is_end && (byte_s1 == CH_CR);
			if (is_end) begin
				count_q <= 8'd0;
				ovf_q   <= 1'b0;
			end else if (is_erase) begin
				count_q <= count_q - 8'd1;
			end else if (is_store) begin
				count_q <= count_q + 8'd1;
			end else if (!drop_lf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			beat_q <= 2'd0;
		end else begin
			if (s2_free) begin
				v_s2 <= adv_s1 && has_res;
			end
			if (out_xfer) begin
				beat_q <= m_axis_tlast ? 2'd0 : beat_q + 2'd1;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && has_res && s2_free) begin
			kind_s2 <= is_end ? KIND_END : (is_erase ? KIND_ERASE : KIND_STORE);
			data_s2 <= byte_s1;
			idx_s2  <= count_q;
			stat_s2 <= ovf_q;
		end
	end

	// expand the burst into single results
	logic [7:0] echo_byte, store_index, line_length;
	logic       store_valid, line_done, line_status;

	always_comb begin
		echo_byte   = 8'd0;
		store_valid = 1'b0;
		store_index = 8'd0;
		line_done   = 1'b0;
		line_length = 8'd0;
		line_status = 1'b0;
		case (kind_s2)
			KIND_END: begin
				echo_byte = (beat_q == 2'd0) ? CH_CR : CH_LF;
				if (beat_q == last_beat(KIND_END)) begin
					line_done   = 1'b1;
					line_length = idx_s2;
					line_status = stat_s2;
				end
			end
			KIND_ERASE: begin
				echo_byte = (beat_q == 2'd1) ? CH_SP : CH_BS;
			end
			KIND_STORE: begin
				echo_byte   = data_s2;
				store_valid = 1'b1;
				store_index = idx_s2;
			end
			default: begin
				echo_byte = 8'd0;
			end
		endcase
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tlast  = (beat_q == last_beat(kind_s2));
	assign m_axis_tdata  = {line_length, store_index, echo_byte};
	assign m_axis_tuser  = {line_status, line_done, store_valid, 1'b1};

	// the line end report only travels on the closing result of a burst
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && line_done) |-> m_axis_tlast)
		else $error("line end reported before the final result");

	// the beat counter stays inside the burst held in the result register
	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (beat_q <= last_beat(kind_s2)))
		else $error("beat counter ran past the burst");

	// a stored character's index always stays below DEPTH_CAP, the largest stored count
	a_store_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && store_valid) |-> (store_index < DEPTH_CAP))
		else $error("store index beyond line store");

	// a byte that gives a result only leaves the input register into a free result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && has_res) |-> s2_free)
		else $error("result register overwritten");

endmodule
